### hw/rtl/sfrc_pkg.sv
package sfrc_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_HEADER_FIRST  = 3'd0;
    localparam logic [2:0] CFG_HEADER_SECOND = 3'd1;
    localparam logic [2:0] CFG_TAIL_FIRST    = 3'd2;
    localparam logic [2:0] CFG_TAIL_SECOND   = 3'd3;
    localparam logic [2:0] CFG_TYPE_MASK     = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_DELIVERED = 2'd0;
    localparam logic [1:0] ST_BAD_SUM   = 2'd1;
    localparam logic [1:0] ST_NO_HANDLER = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] tail_first;
        logic [7:0] tail_second;
        logic [7:0] type_mask;
    } t_cfg;

    // One completed frame, passed from parser to checker
    typedef struct packed {
        logic [7:0]  kind;
        logic [3:0]  count;
        logic [63:0] payload;
        logic [15:0] sum;
        logic [15:0] sent_sum;
    } t_frame_rec;

endpackage

### hw/rtl/sfrc_front.sv
module sfrc_front import sfrc_pkg::*; #(
    parameter int PAYLOAD_MAX = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_beat,
    input  logic [7:0] i_rx_byte,
    output logic       o_rec_push,
    output t_frame_rec o_rec
);

    localparam logic [3:0] PH_HEAD1 = 4'd0;
    localparam logic [3:0] PH_HEAD2 = 4'd1;
    localparam logic [3:0] PH_KIND  = 4'd2;
    localparam logic [3:0] PH_LEN   = 4'd3;
    localparam logic [3:0] PH_DATA  = 4'd4;
    localparam logic [3:0] PH_SUMH  = 4'd5;
    localparam logic [3:0] PH_SUML  = 4'd6;
    localparam logic [3:0] PH_TAIL1 = 4'd7;
    localparam logic [3:0] PH_TAIL2 = 4'd8;

    logic [3:0]  r_phase, n_phase;
    logic [7:0]  r_kind;
    logic [3:0]  r_count;
    logic [3:0]  r_fill;
    logic [63:0] r_payload;
    logic [15:0] r_sum;
    logic [7:0]  r_sent_hi;
    logic [7:0]  r_sent_lo;

    logic [3:0]  w_len_clamped;
    logic [3:0]  w_fill_next;

    assign w_len_clamped = (i_rx_byte > 8'(PAYLOAD_MAX)) ? 4'(PAYLOAD_MAX) : i_rx_byte[3:0];
    assign w_fill_next   = r_fill + 4'd1;

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HEAD1: if (i_rx_byte == i_cfg.header_first) n_phase = PH_HEAD2;
            PH_HEAD2: n_phase = (i_rx_byte == i_cfg.header_second) ? PH_KIND : PH_HEAD1;
            PH_KIND:  n_phase = PH_LEN;
            PH_LEN:   n_phase = (w_len_clamped != 4'd0) ? PH_DATA : PH_SUMH;
            PH_DATA:  if (w_fill_next >= r_count) n_phase = PH_SUMH;
            PH_SUMH:  n_phase = PH_SUML;
            PH_SUML:  n_phase = PH_TAIL1;
            PH_TAIL1: n_phase = (i_rx_byte == i_cfg.tail_first) ? PH_TAIL2 : PH_HEAD1;
            PH_TAIL2: n_phase = PH_HEAD1;
            default:  n_phase = PH_HEAD1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD1;
        end else if (i_beat) begin
            r_phase <= n_phase;
        end
    end

    // Frame payload registers; old bytes are cleared at the length byte
    always_ff @(posedge i_clk) begin
        if (i_beat) begin
            case (r_phase)
                PH_KIND: r_kind <= i_rx_byte;
                PH_LEN: begin
                    r_count   <= w_len_clamped;
                    r_fill    <= 4'd0;
                    r_payload <= '0;
                    r_sum     <= 16'(r_kind) + 16'(w_len_clamped);
                end
                PH_DATA: begin
                    r_payload[8*r_fill[2:0] +: 8] <= i_rx_byte;
                    r_fill <= w_fill_next;
                    r_sum  <= r_sum + 16'(i_rx_byte);
                end
                PH_SUMH: r_sent_hi <= i_rx_byte;
                PH_SUML: r_sent_lo <= i_rx_byte;
                default: ;
            endcase
        end
    end

    assign o_rec_push = i_beat && (r_phase == PH_TAIL2) && (i_rx_byte == i_cfg.tail_second);

    assign o_rec.kind     = r_kind;
    assign o_rec.count    = r_count;
    assign o_rec.payload  = r_payload;
    assign o_rec.sum      = r_sum;
    assign o_rec.sent_sum = {r_sent_hi, r_sent_lo};

endmodule

### hw/rtl/sfrc_queue.sv
module sfrc_queue import sfrc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_rec i_rec,
    input  logic       i_pop,
    output logic       o_full,
    output logic       o_valid,
    output t_frame_rec o_rec
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_frame_rec r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;

    logic w_wr;
    logic w_rd;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rptr];

    assign w_wr = i_push && !o_full;
    assign w_rd = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

endmodule

### hw/rtl/sfrc_back.sv
module sfrc_back import sfrc_pkg::*; #(
    parameter int TYPE_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_type_mask,
    input  logic        i_rec_valid,
    input  t_frame_rec  i_rec,
    output logic        o_rec_pop,
    output logic        o_out_valid,
    input  logic        i_out_take,
    output logic [1:0]  o_frame_status,
    output logic [7:0]  o_frame_kind,
    output logic [3:0]  o_payload_count,
    output logic [63:0] o_payload_bytes,
    output logic [15:0] o_computed_sum
);

    logic        r_valid;
    logic [1:0]  r_status;
    logic [7:0]  r_kind;
    logic [3:0]  r_count;
    logic [63:0] r_payload;
    logic [15:0] r_sum;

    logic       w_enabled;
    logic [1:0] w_status;

    assign w_enabled = ({24'd0, i_rec.kind} < 32'(TYPE_COUNT)) && (i_rec.kind < 8'd8)
                       && i_type_mask[i_rec.kind[2:0]];

    always_comb begin
        if (i_rec.sum != i_rec.sent_sum) begin
            w_status = ST_BAD_SUM;
        end else if (!w_enabled) begin
            w_status = ST_NO_HANDLER;
        end else begin
            w_status = ST_DELIVERED;
        end
    end

    // Output register refills in the cycle it is taken, if a record is queued
    assign o_rec_pop = i_rec_valid && (!r_valid || i_out_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rec_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_pop) begin
            r_status  <= w_status;
            r_kind    <= i_rec.kind;
            r_count   <= i_rec.count;
            r_payload <= i_rec.payload;
            r_sum     <= i_rec.sum;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_frame_status  = r_status;
    assign o_frame_kind    = r_kind;
    assign o_payload_count = r_count;
    assign o_payload_bytes = r_payload;
    assign o_computed_sum  = r_sum;

endmodule

### hw/rtl/serial_frame_receiver_checksum.sv
// Serial frame receiver with additive checksum.
//
// Input side is a queue write port: one received byte per beat on i_rx_byte,
// taken when push is high and full is low. Frames are header_first,
// header_second, type, length, payload (length clamped to PAYLOAD_MAX),
// checksum high, checksum low, tail_first, tail_second.
// Result side is a queue read port: while empty is low the oldest frame
// report sits on the o_* ports; pop takes it. One report per frame that ends
// in a matching tail_second byte; status says delivered, bad checksum or no
// handler for the type.
// Throughput: one byte per cycle while full is low. The parser FSM keeps a running sum, so the
// only per-byte work is one 16-bit add. A report passes from the tail_second
// beat via the record queue, then the checker output register, to empty low.
// The parser stalls (full high) only when the 2-entry record queue between
// parser and checker is full, i.e. when the receiver has left reports
// unpopped; a held report does not block the next bytes otherwise.
// Reset (i_rst_n low, synchronous): parser waits for header_first, queues
// empty, all config registers zero. Config writes are taken at any index;
// indexes above the type mask are ignored.
module serial_frame_receiver_checksum import sfrc_pkg::*; #(
    parameter int PAYLOAD_MAX = 8,
    parameter int TYPE_COUNT  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    // byte input
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    // frame reports
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_frame_status,
    output logic [7:0]  o_frame_kind,
    output logic [3:0]  o_payload_count,
    output logic [63:0] o_payload_bytes,
    output logic [15:0] o_computed_sum
);

    t_cfg       r_cfg;
    logic       w_beat;
    logic       w_rec_push;
    t_frame_rec w_front_rec;
    logic       w_q_full;
    logic       w_q_valid;
    logic       w_q_pop;
    t_frame_rec w_q_rec;
    logic       w_out_valid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_HEADER_FIRST:  r_cfg.header_first  <= i_cfg_wdata;
                CFG_HEADER_SECOND: r_cfg.header_second <= i_cfg_wdata;
                CFG_TAIL_FIRST:    r_cfg.tail_first    <= i_cfg_wdata;
                CFG_TAIL_SECOND:   r_cfg.tail_second   <= i_cfg_wdata;
                CFG_TYPE_MASK:     r_cfg.type_mask     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Any byte may close a frame, so hold input whenever the queue is full
    assign full   = w_q_full;
    assign w_beat = push && !full;

    sfrc_front #(
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_beat     (w_beat),
        .i_rx_byte  (i_rx_byte),
        .o_rec_push (w_rec_push),
        .o_rec      (w_front_rec)
    );

    sfrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rec_push),
        .i_rec   (w_front_rec),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_rec   (w_q_rec)
    );

    sfrc_back #(
        .TYPE_COUNT(TYPE_COUNT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_type_mask     (r_cfg.type_mask),
        .i_rec_valid     (w_q_valid),
        .i_rec           (w_q_rec),
        .o_rec_pop       (w_q_pop),
        .o_out_valid     (w_out_valid),
        .i_out_take      (pop),
        .o_frame_status  (o_frame_status),
        .o_frame_kind    (o_frame_kind),
        .o_payload_count (o_payload_count),
        .o_payload_bytes (o_payload_bytes),
        .o_computed_sum  (o_computed_sum)
    );

    assign empty = !w_out_valid;

    // A report can only appear after a record left the queue
    a_report_from_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(empty) |-> $past(w_q_valid))
        else $error("report appeared without a queued frame");

    // Status is one of the three defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_frame_status == ST_DELIVERED || o_frame_status == ST_BAD_SUM
                    || o_frame_status == ST_NO_HANDLER))
        else $error("undefined frame status");

    // Clamped length never exceeds the payload store
    a_count_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_payload_count <= 4'(PAYLOAD_MAX)))
        else $error("payload count above limit");

    // A delivered frame has a type inside the handler table
    a_delivered_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_status == ST_DELIVERED) |-> (o_frame_kind < 8'd8))
        else $error("delivered frame with out-of-range type");

endmodule
